@@ design/rse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg: shared constants for the rANS symbol encoder
// Field widths, command and result codes, and parameter defaults that the
// encoder, its divider and its checker have in common.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int STATE_W  = 24;
  localparam int FREQ_W   = 13;
  localparam int TOTAL_W  = 21;
  localparam int PLOG_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int KIND_W   = 2;

  localparam int MIN_PRECISION_LOG     = 5;
  localparam int DEF_MAX_PRECISION_LOG = 12;
  localparam int DEF_SYMBOL_COUNT      = 256;

  // Lower bound of the normalized coder state.
  localparam logic [STATE_W-1:0] LOWER_BOUND = 24'd65536;

  // Renormalization limit f << (STATE_W - precision_log) at the smallest precision.
  localparam int LIM_W = FREQ_W + STATE_W - MIN_PRECISION_LOG;

  // Command codes on func.
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENCODE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

  // Result codes on kind.
  localparam logic [KIND_W-1:0] KIND_BYTE       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINAL      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_SYMBOL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_TOTAL  = 2'd3;

endpackage
`default_nettype wire

@@ design/rse_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/rse_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_divider: bit-serial restoring divider
// Shifts the dividend through a register one bit per cycle and develops one
// quotient bit per cycle; done pulses when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module rse_divider #(
  parameter int DIVIDEND_W = rse_pkg::STATE_W,
  parameter int DIVISOR_W  = rse_pkg::FREQ_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [DIVIDEND_W-1:0] quotient,
  output logic      [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      count;
  logic [DIVIDEND_W-1:0] shift_q;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  div_reg;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // The remainder always stays below the divisor, so the trial fits one extra bit.
  assign trial = {rem, shift_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_reg};
  assign fits  = trial >= {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(DIVIDEND_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
        done  <= (count == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift_q <= dividend;
      rem     <= '0;
      div_reg <= divisor;
    end else if (count != '0) begin
      shift_q <= {shift_q[DIVIDEND_W-2:0], fits};
      rem     <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = shift_q;
  assign remainder = rem;

endmodule
`default_nettype wire

@@ design/rans_symbol_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rans_symbol_encoder: range ANS encoder with byte-wise renormalization
// Loads a normalized frequency table, encodes byte symbols into a 24-bit
// coder state, and reports emitted bytes, the final state and errors.
// ----------------------------------------------------------------------------
// The encoder works on one item at a time and is ready for a new item whenever
// its sequencer is idle, even while the previous result still waits in the
// output register. A load or a restart is done as it is accepted. A finish, or
// an encode that fails its table or symbol check, goes through the report state
// and waits there for the output register to be free. A good encode is
// accepted, reads the table RAM, takes one renormalization step per emitted
// byte (each waiting for the output register) and one more to start the
// division, runs the bit-serial divider (one quotient bit per cycle, which
// sets the rate), then scales the quotient and adds the remainder and the
// cumulative start. Symbols must be fed last to first.
// Frequencies are loaded in symbol order after a restart; the block builds
// the cumulative starts itself. An encode checks first that the loaded total
// equals 2^precision_log, then that the symbol was loaded with a non-zero
// frequency; either failure gives a single error result and leaves the state
// alone. precision_log may be written only while the block is idle; values
// outside 5..MAX_PRECISION_LOG are clamped.
// ----------------------------------------------------------------------------
module rans_symbol_encoder #(
  parameter int SYMBOL_COUNT      = rse_pkg::DEF_SYMBOL_COUNT,
  parameter int MAX_PRECISION_LOG = rse_pkg::DEF_MAX_PRECISION_LOG
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration write port for precision_log.
  input  wire logic                        cfg_wr_en,
  input  wire logic [rse_pkg::PLOG_W-1:0]  cfg_wr_data,
  // Item channel.
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire logic [rse_pkg::FUNC_W-1:0]  func,
  input  wire logic [rse_pkg::BYTE_W-1:0]  symbol,
  input  wire logic [rse_pkg::FREQ_W-1:0]  frequency,
  // Result channel.
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic      [rse_pkg::KIND_W-1:0]  kind,
  output logic      [rse_pkg::BYTE_W-1:0]  out_byte,
  output logic      [rse_pkg::STATE_W-1:0] state_word,
  output logic                             last
);

  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int CNT_W   = $clog2(SYMBOL_COUNT + 1);
  localparam int CMP_W   = (CNT_W > rse_pkg::BYTE_W) ? CNT_W : rse_pkg::BYTE_W;
  localparam int ENTRY_W = 2 * rse_pkg::FREQ_W;
  localparam int SUM_W   = rse_pkg::FREQ_W + 1;
  localparam int STATE_W = rse_pkg::STATE_W;
  localparam int LIM_W   = rse_pkg::LIM_W;
  localparam int PLOG_W  = rse_pkg::PLOG_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_RENORM = 6'b000100,
    S_DIVIDE = 6'b001000,
    S_SUM    = 6'b010000,
    S_REPORT = 6'b100000
  } seq_state_t;

  seq_state_t                     state;
  logic [PLOG_W-1:0]              precision_log;
  logic [CNT_W-1:0]               loaded_count;
  logic [rse_pkg::TOTAL_W-1:0]    running_total;
  logic [STATE_W-1:0]             coder_state;

  // Working registers of one encode.
  logic [STATE_W-1:0]             x;
  logic [LIM_W-1:0]               lim;
  logic [1:0]                     emit_count;
  logic [rse_pkg::FREQ_W-1:0]     freq_reg;
  logic [rse_pkg::FREQ_W-1:0]     start_reg;
  logic [STATE_W-1:0]             scaled_q;
  logic [SUM_W-1:0]               offset;
  logic [rse_pkg::KIND_W-1:0]     res_kind;

  logic                           accept;
  logic                           table_open;
  logic                           total_ok;
  logic                           sym_loaded;
  logic                           out_free;
  logic                           need_emit;
  logic                           emit_last;
  logic                           res_load;
  logic [PLOG_W-1:0]              plog_clamped;

  logic                           ram_wr_en;
  logic                           ram_rd_en;
  logic [ENTRY_W-1:0]             ram_rd_data;
  logic [rse_pkg::FREQ_W-1:0]     rd_freq;
  logic [rse_pkg::FREQ_W-1:0]     rd_start;

  logic                           div_start;
  logic                           div_done;
  logic [STATE_W-1:0]             div_quotient;
  logic [rse_pkg::FREQ_W-1:0]     div_remainder;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  assign table_open = loaded_count < CNT_W'(SYMBOL_COUNT);
  assign total_ok   = running_total == (rse_pkg::TOTAL_W'(1) << precision_log);
  assign sym_loaded = CMP_W'(symbol) < CMP_W'(loaded_count);

  // Out-of-range precision writes saturate at the supported limits.
  always_comb begin
    plog_clamped = cfg_wr_data;
    if (cfg_wr_data < PLOG_W'(rse_pkg::MIN_PRECISION_LOG)) begin
      plog_clamped = PLOG_W'(rse_pkg::MIN_PRECISION_LOG);
    end else if (cfg_wr_data > PLOG_W'(MAX_PRECISION_LOG)) begin
      plog_clamped = PLOG_W'(MAX_PRECISION_LOG);
    end
  end

  // Each table entry holds the frequency and its cumulative start side by side.
  assign ram_wr_en = accept && (func == rse_pkg::FUNC_LOAD) && table_open;
  assign ram_rd_en = accept && (func == rse_pkg::FUNC_ENCODE);
  assign rd_freq   = ram_rd_data[ENTRY_W-1:rse_pkg::FREQ_W];
  assign rd_start  = ram_rd_data[rse_pkg::FREQ_W-1:0];

  rse_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (loaded_count[ADDR_W-1:0]),
    .wr_data ({frequency, running_total[rse_pkg::FREQ_W-1:0]}),
    .rd_en   (ram_rd_en),
    .rd_addr (symbol[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // A byte goes out while the state is at or above f << (24 - precision_log),
  // at most twice per symbol. The last byte is the one after which no
  // further byte would follow.
  assign need_emit = (emit_count != 2'd2) && (LIM_W'(x) >= lim);
  assign emit_last = (emit_count == 2'd1) || (LIM_W'(x >> rse_pkg::BYTE_W) < lim);
  assign div_start = (state == S_RENORM) && !need_emit;

  // The output register takes a new result when a byte or a report is ready
  // and the register is free or being emptied in the same cycle.
  assign res_load = out_free &&
                    (((state == S_RENORM) && need_emit) || (state == S_REPORT));

  rse_divider #(
    .DIVIDEND_W (STATE_W),
    .DIVISOR_W  (rse_pkg::FREQ_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (x),
    .divisor   (freq_reg),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      precision_log <= PLOG_W'(rse_pkg::MIN_PRECISION_LOG);
      loaded_count  <= '0;
      running_total <= '0;
      coder_state   <= rse_pkg::LOWER_BOUND;
      result_valid  <= 1'b0;
    end else begin
      // The output register refills when a result is ready and otherwise
      // empties on a transfer.
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        precision_log <= plog_clamped;
      end

      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (func)
              rse_pkg::FUNC_LOAD: begin
                // A load into a full table is dropped.
                if (table_open) begin
                  loaded_count  <= loaded_count + CNT_W'(1);
                  running_total <= running_total + rse_pkg::TOTAL_W'(frequency);
                end
              end
              rse_pkg::FUNC_ENCODE: begin
                if (!total_ok) begin
                  res_kind <= rse_pkg::KIND_BAD_TOTAL;
                  state    <= S_REPORT;
                end else if (!sym_loaded) begin
                  res_kind <= rse_pkg::KIND_BAD_SYMBOL;
                  state    <= S_REPORT;
                end else begin
                  state <= S_READ;
                end
              end
              rse_pkg::FUNC_FINISH: begin
                res_kind <= rse_pkg::KIND_FINAL;
                state    <= S_REPORT;
              end
              rse_pkg::FUNC_RESTART: begin
                coder_state   <= rse_pkg::LOWER_BOUND;
                loaded_count  <= '0;
                running_total <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        S_READ: begin
          if (rd_freq == '0) begin
            res_kind <= rse_pkg::KIND_BAD_SYMBOL;
            state    <= S_REPORT;
          end else begin
            freq_reg   <= rd_freq;
            start_reg  <= rd_start;
            lim        <= LIM_W'(rd_freq) << (5'(STATE_W) - 5'(precision_log));
            x          <= coder_state;
            emit_count <= 2'd0;
            state      <= S_RENORM;
          end
        end

        S_RENORM: begin
          if (need_emit) begin
            if (out_free) begin
              kind         <= rse_pkg::KIND_BYTE;
              out_byte     <= x[rse_pkg::BYTE_W-1:0];
              state_word   <= '0;
              last         <= emit_last;
              x            <= x >> rse_pkg::BYTE_W;
              emit_count   <= emit_count + 2'd1;
            end
          end else begin
            state <= S_DIVIDE;
          end
        end

        S_DIVIDE: begin
          if (div_done) begin
            scaled_q <= div_quotient << precision_log;
            offset   <= SUM_W'(div_remainder) + SUM_W'(start_reg);
            state    <= S_SUM;
          end
        end

        S_SUM: begin
          coder_state <= scaled_q + STATE_W'(offset);
          state       <= S_IDLE;
        end

        S_REPORT: begin
          if (out_free) begin
            kind         <= res_kind;
            out_byte     <= '0;
            state_word   <= (res_kind == rse_pkg::KIND_FINAL) ? coder_state : '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/rse_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rse_checker: port-level checks for the rANS symbol encoder
// Watches the result channel for field consistency and stall behavior.
// ----------------------------------------------------------------------------
module rse_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        result_valid,
  input wire logic                        result_ready,
  input wire logic [rse_pkg::KIND_W-1:0]  kind,
  input wire logic [rse_pkg::BYTE_W-1:0]  out_byte,
  input wire logic [rse_pkg::STATE_W-1:0] state_word,
  input wire logic                        last
);

  // Final-state and error results are always the only result of their item.
  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != rse_pkg::KIND_BYTE) |-> last)
    else $error("non-byte result without last");

  // Only a final-state result carries a state value.
  a_state_only_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != rse_pkg::KIND_FINAL) |-> (state_word == '0))
    else $error("state field set on a result that is not the final state");

  // Only a byte result carries a byte value.
  a_byte_only_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind != rse_pkg::KIND_BYTE) |-> (out_byte == '0))
    else $error("byte field set on a result that is not a byte");

  // A stalled result holds until its transfer.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(kind) && $stable(out_byte) &&
      $stable(state_word) && $stable(last))
    else $error("result changed while stalled");

endmodule

bind rans_symbol_encoder rse_checker u_rse_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .kind         (kind),
  .out_byte     (out_byte),
  .state_word   (state_word),
  .last         (last)
);
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rANS symbol encoder
// Drives loads, encodes, finishes and restarts through the item channel
// under several table precisions. Each result is checked field by field
// against a behavioral coder that tracks the frequency table, the
// cumulative starts and the 24-bit state.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FUNC_W  = rse_pkg::FUNC_W;
  localparam int BYTE_W  = rse_pkg::BYTE_W;
  localparam int FREQ_W  = rse_pkg::FREQ_W;
  localparam int KIND_W  = rse_pkg::KIND_W;
  localparam int STATE_W = rse_pkg::STATE_W;
  localparam int PLOG_W  = rse_pkg::PLOG_W;
  localparam int TOTAL_W = rse_pkg::TOTAL_W;

  localparam int SYMBOLS       = rse_pkg::DEF_SYMBOL_COUNT;
  localparam int TAB_AW        = $clog2(SYMBOLS);
  localparam int MAX_PLOG      = rse_pkg::DEF_MAX_PRECISION_LOG;
  localparam int ITEM_TARGET   = 850;
  // This pause covers an encode that emits nothing and is still in the divider.
  localparam int SETTLE_CYCLES = 64;
  // The slowest healthy gap between transfers is the receiver hold-off below
  // plus one encode; the watchdog limit lies above that.
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 400;
  // The hold-off starts only while more than this many items still wait to be sent.
  localparam int HOLD_BACKLOG  = 8;
  // Neither side idles at random inside this window of cycles.
  localparam int QUIET_START   = 2000;
  localparam int QUIET_END     = 6000;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic [BYTE_W-1:0] sym;
    logic [FREQ_W-1:0] freq;
  } coder_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [BYTE_W-1:0]  data;
    logic [STATE_W-1:0] state;
    logic               tail;
  } coder_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [PLOG_W-1:0]   cfg_wr_data;
  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [FUNC_W-1:0]   func = rse_pkg::FUNC_LOAD;
  logic [BYTE_W-1:0]   symbol = '0;
  logic [FREQ_W-1:0]   frequency = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATE_W-1:0]  state_word;
  logic                last;

  rans_symbol_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .symbol       (symbol),
    .frequency    (frequency),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .state_word   (state_word),
    .last         (last)
  );

  // Stimulus waiting for the driver, and results the coder has promised.
  coder_cmd_t    pending_cmds[$];
  coder_result_t awaited_results[$];
  int            queued_items = 0;
  int            error_count = 0;
  int            results_seen = 0;
  int            cycle_n = 0;

  // Behavioral copy of the encoder state. Table entries at or above
  // table_count are never read, so the arrays need no reset.
  logic [FREQ_W-1:0]  freq_tab[SYMBOLS];
  logic [FREQ_W-1:0]  start_tab[SYMBOLS];
  logic [8:0]         table_count = '0;
  logic [TOTAL_W-1:0] table_sum = '0;
  logic [STATE_W-1:0] coder_x = rse_pkg::LOWER_BOUND;
  logic [PLOG_W-1:0]  coder_plog = PLOG_W'(rse_pkg::MIN_PRECISION_LOG);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_roll();
    if (cycle_n >= QUIET_START && cycle_n < QUIET_END) return 1'b0;
    return $urandom_range(0, 99) < 13;
  endfunction

  function automatic void expect_result(input logic [KIND_W-1:0] k,
                                        input logic [BYTE_W-1:0] b,
                                        input logic [STATE_W-1:0] s,
                                        input logic t);
    coder_result_t r;
    r.kind  = k;
    r.data  = b;
    r.state = s;
    r.tail  = t;
    awaited_results.push_back(r);
  endfunction

  // Advances the coder by one accepted item and queues what it must emit.
  task automatic coder_step(input coder_cmd_t c);
    longint unsigned x, y, f, lim;
    int n;
    case (c.op)
      rse_pkg::FUNC_LOAD: begin
        // Loads past the last table slot are dropped.
        if (table_count < SYMBOLS) begin
          freq_tab[table_count[TAB_AW-1:0]]  = c.freq;
          start_tab[table_count[TAB_AW-1:0]] = table_sum[FREQ_W-1:0];
          table_sum   = table_sum + c.freq;
          table_count = table_count + 1'b1;
        end
      end
      rse_pkg::FUNC_ENCODE: begin
        // The table total is checked before the symbol itself.
        if (table_sum != (21'd1 << coder_plog)) begin
          expect_result(rse_pkg::KIND_BAD_TOTAL, '0, '0, 1'b1);
        end else if (c.sym >= table_count || freq_tab[c.sym] == '0) begin
          expect_result(rse_pkg::KIND_BAD_SYMBOL, '0, '0, 1'b1);
        end else begin
          f   = freq_tab[c.sym];
          x   = coder_x;
          lim = ((64'd65536 >> coder_plog) << 8) * f;
          y   = x;
          n   = 0;
          while (y >= lim && n < 2) begin
            n++;
            y = y >> 8;
          end
          // Bytes leave low byte first; the last one carries the tail flag.
          for (int i = 0; i < n; i++) begin
            expect_result(rse_pkg::KIND_BYTE, BYTE_W'(x >> (8 * i)), '0, i == n - 1);
          end
          y = ((y / f) << coder_plog) + (y % f) + start_tab[c.sym];
          coder_x = y[STATE_W-1:0];
        end
      end
      rse_pkg::FUNC_FINISH: begin
        expect_result(rse_pkg::KIND_FINAL, '0, coder_x, 1'b1);
      end
      rse_pkg::FUNC_RESTART: begin
        coder_x     = rse_pkg::LOWER_BOUND;
        table_count = '0;
        table_sum   = '0;
      end
      default: ;
    endcase
  endtask

  // Driver: presents the next pending item whenever the channel is free and
  // the sender is not idling. Prediction happens on the transfer itself.
  always @(posedge clk) begin
    coder_cmd_t c;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        c.op   = func;
        c.sym  = symbol;
        c.freq = frequency;
        coder_step(c);
      end
      if (!item_valid || item_ready) begin
        if (pending_cmds.size() != 0 && !idle_roll()) begin
          c = pending_cmds.pop_front();
          item_valid <= 1'b1;
          func       <= c.op;
          symbol     <= c.sym;
          frequency  <= c.freq;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string what, input logic [STATE_W-1:0] want,
                             input logic [STATE_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      error_count++;
    end
  endtask

  // Monitor: checks every result transfer against the oldest expectation.
  // Once, after a few dozen results and while plenty of items still wait,
  // the receiver holds off for a long stretch so the output register fills
  // and the item channel backs up.
  always @(posedge clk) begin
    coder_result_t want;
    int hold_left;
    bit hold_done;
    if (rst) begin
      result_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, got kind %0d byte 0x%0h",
                   $time, kind, out_byte);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", STATE_W'(want.kind), STATE_W'(kind));
          check_field("out_byte", STATE_W'(want.data), STATE_W'(out_byte));
          check_field("state_word", want.state, state_word);
          check_field("last", STATE_W'(want.tail), STATE_W'(last));
        end
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_AT && pending_cmds.size() > HOLD_BACKLOG) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !idle_roll();
      end
    end
  end

  // Watchdog: ends the run if neither channel completes a transfer for too long.
  always @(posedge clk) begin
    int stall_n;
    if (rst) begin
      stall_n = 0;
    end else begin
      cycle_n++;
      if ((item_valid && item_ready) || (result_valid && result_ready)) stall_n = 0;
      else stall_n++;
      if (stall_n == STALL_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL rans_symbol_encoder");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [FUNC_W-1:0] op, input int sym, input int freq);
    coder_cmd_t c;
    c.op   = op;
    c.sym  = BYTE_W'(sym);
    c.freq = FREQ_W'(freq);
    pending_cmds.push_back(c);
    queued_items++;
  endtask

  // Waits until every item is taken and every result has come back, then
  // lets the block finish any encode that emits nothing.
  task automatic settle();
    while (pending_cmds.size() != 0 || item_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes precision_log; only called while the block is idle.
  task automatic write_precision(input logic [PLOG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    if (v < rse_pkg::MIN_PRECISION_LOG) coder_plog = PLOG_W'(rse_pkg::MIN_PRECISION_LOG);
    else if (v > MAX_PLOG) coder_plog = PLOG_W'(MAX_PLOG);
    else coder_plog = v;
  endtask

  // Queues one coding block: a restart, a table that sums to the current
  // total, encodes of mostly live symbols and a finish. Some blocks get a
  // spoiled table sum, and some are plain noise. With fill_all the table
  // takes every symbol slot and two more loads that must be dropped.
  task automatic queue_block(input bit fill_all);
    int roll, nsym, idx, prev, total;
    int cuts[$];
    int freqs[$];
    int live[$];
    total = 1 << coder_plog;
    roll  = fill_all ? 0 : $urandom_range(0, 99);
    if (roll >= 87) begin
      repeat ($urandom_range(5, 15))
        push_cmd(FUNC_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                 $urandom_range(0, 4096));
      return;
    end
    if (fill_all) nsym = SYMBOLS;
    else if ($urandom_range(0, 9) == 0) nsym = $urandom_range(2, SYMBOLS);
    else nsym = $urandom_range(2, 16);
    // Random cut points split the total; repeated cuts give zero counts.
    repeat (nsym - 1) cuts.push_back($urandom_range(0, total));
    cuts.push_back(total);
    cuts.sort();
    prev = 0;
    foreach (cuts[i]) begin
      freqs.push_back(cuts[i] - prev);
      prev = cuts[i];
    end
    if (roll >= 75) begin
      idx = $urandom_range(0, nsym - 1);
      if ($urandom_range(0, 1) == 0) freqs[idx] = $urandom_range(0, 4096);
      else freqs.delete(idx);
    end
    push_cmd(rse_pkg::FUNC_RESTART, $urandom_range(0, 255), $urandom_range(0, 4096));
    foreach (freqs[i]) begin
      push_cmd(rse_pkg::FUNC_LOAD, $urandom_range(0, 255), freqs[i]);
      if (freqs[i] != 0) live.push_back(i);
    end
    if (fill_all) begin
      repeat (2) push_cmd(rse_pkg::FUNC_LOAD, $urandom_range(0, 255),
                          $urandom_range(1, 4096));
    end
    if (live.size() == 0) live.push_back(0);
    repeat ($urandom_range(4, 24)) begin
      if ($urandom_range(0, 9) == 0)
        push_cmd(rse_pkg::FUNC_ENCODE, $urandom_range(0, 255), $urandom_range(0, 4096));
      else
        push_cmd(rse_pkg::FUNC_ENCODE, live[$urandom_range(0, live.size() - 1)],
                 $urandom_range(0, 4096));
      if ($urandom_range(0, 19) == 0)
        push_cmd(rse_pkg::FUNC_FINISH, $urandom_range(0, 255), $urandom_range(0, 4096));
    end
    push_cmd(rse_pkg::FUNC_FINISH, $urandom_range(0, 255), $urandom_range(0, 4096));
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A write below the legal range must clamp to the smallest precision.
    write_precision(4'd0);
    // Encode and finish straight out of reset: the empty table fails its sum.
    push_cmd(rse_pkg::FUNC_ENCODE, 0, 0);
    push_cmd(rse_pkg::FUNC_FINISH, 0, 0);
    // Table of 0, 1, 31: one dead symbol, one rare, one common.
    push_cmd(rse_pkg::FUNC_LOAD, 0, 0);
    push_cmd(rse_pkg::FUNC_LOAD, 0, 1);
    push_cmd(rse_pkg::FUNC_LOAD, 0, 31);
    push_cmd(rse_pkg::FUNC_ENCODE, 0, 0);
    push_cmd(rse_pkg::FUNC_ENCODE, 255, 0);
    push_cmd(rse_pkg::FUNC_ENCODE, 1, 0);
    push_cmd(rse_pkg::FUNC_ENCODE, 1, 0);
    push_cmd(rse_pkg::FUNC_FINISH, 0, 0);
    // One more load breaks the table total.
    push_cmd(rse_pkg::FUNC_LOAD, 0, 1);
    push_cmd(rse_pkg::FUNC_ENCODE, 2, 0);
    push_cmd(rse_pkg::FUNC_FINISH, 0, 0);
    settle();

    // A write above the range must clamp to the largest precision.
    write_precision(4'd15);
    // A single symbol that owns the whole table leaves the state unchanged.
    push_cmd(rse_pkg::FUNC_RESTART, 0, 0);
    push_cmd(rse_pkg::FUNC_LOAD, 0, 4096);
    push_cmd(rse_pkg::FUNC_ENCODE, 0, 0);
    push_cmd(rse_pkg::FUNC_ENCODE, 0, 0);
    push_cmd(rse_pkg::FUNC_FINISH, 0, 0);
    // A rare symbol at full precision makes the second encode emit two bytes.
    push_cmd(rse_pkg::FUNC_RESTART, 0, 0);
    push_cmd(rse_pkg::FUNC_LOAD, 0, 1);
    push_cmd(rse_pkg::FUNC_LOAD, 0, 4095);
    push_cmd(rse_pkg::FUNC_ENCODE, 0, 0);
    push_cmd(rse_pkg::FUNC_ENCODE, 0, 0);
    push_cmd(rse_pkg::FUNC_ENCODE, 1, 0);
    push_cmd(rse_pkg::FUNC_FINISH, 0, 0);
    settle();

    // Random part, first filling every table slot once.
    write_precision(PLOG_W'($urandom_range(0, 15)));
    queue_block(1'b1);
    while (queued_items < ITEM_TARGET) begin
      settle();
      write_precision(PLOG_W'($urandom_range(0, 15)));
      repeat ($urandom_range(2, 4)) queue_block(1'b0);
    end
    settle();

    if (error_count == 0) begin
      $display("PASS rans_symbol_encoder");
    end else begin
      $display("FAIL rans_symbol_encoder");
    end
    $finish;
  end

endmodule
